// File: hdl/chip8_instruction_executor_unit_defines.svh
// Assertion macros used by the checker file of the CHIP-8 executor.
`ifndef CHIP8_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH
// Implication that must hold at every clock edge outside reset.
`define C8_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define C8_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);
`endif

// File: hdl/c8x_pkg.sv
// Package: shared types and constants of the CHIP-8 executor.
`default_nettype none
package c8x_pkg;
  localparam int STACK_DEPTH = 16;
  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam int SCREEN_WIDTH = 64;
  localparam int SCREEN_ROWS = 32;
  localparam logic [11:0] START_PC = 12'h200;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_ROW   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MEMWR, S_ROWRD, S_MEMRD, S_MEMRD_W,
    S_FETCH_HI, S_FETCH_LO, S_FETCH_W, S_DECODE,
    S_CLS, S_DRAW_RD, S_DRAW_W, S_DRAW_ROW, S_DRAW_WR, S_DRAW_DONE,
    S_BCD_DIV, S_BCD_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] address;
    logic [7:0]  write_value;
    logic [15:0] key_state;
    logic [7:0]  random_byte;
  } req_t;

  typedef struct packed {
    logic [11:0] pc_after;
    logic [15:0] fetched_word;
    logic        drew_sprite;
    logic        unknown_instr;
    logic [63:0] read_data;
  } rsp_t;
endpackage
`default_nettype wire

// File: hdl/c8x_chan_if.sv
// Interface: valid/ready channel carrying one payload struct.
`default_nettype none
interface c8x_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/chip8_instruction_executor_unit.sv
// Top level: CHIP-8 executor with memory, frame buffer and a small sequencer.
// Usage: one request channel (req) and one response channel (rsp), both
// valid/ready. Each request yields exactly one response.
// op 0 writes a memory byte, op 3 reads one, op 2 reads a display row.
// op 1 executes the instruction at PC: fetch takes two memory reads. For DXYN
// each sprite row costs a memory read and a read-modify-write of one frame
// row. 00E0 sweeps the 32 rows; FX33 splits Vx into digits by repeated
// subtraction on the shared 8-bit subtractor and writes three bytes.
// One request is in flight at a time; req.ready is high only while idle with
// no response waiting. The response is held in an output register until
// rsp.ready; a stalled receiver stalls the block, nothing is lost.
// Reset: PC = 0x200, registers, stack and timers cleared; the frame is
// cleared by a sweep of all 32 rows after reset, during which req.ready is low.
// Memory content is undefined until written.
`default_nettype none
module chip8_instruction_executor_unit
  import c8x_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  c8x_chan_if.sink   req,
  c8x_chan_if.source rsp
);
  // architectural state
  logic [11:0] pc, pc_next;
  logic [7:0]  vreg [16];
  logic [11:0] index_reg, index_next;
  logic [11:0] stack [STACK_DEPTH];
  logic [SP_W-1:0] sp, sp_next;
  logic [7:0]  delay_count, sound_count;
  logic [7:0]  mem [4096];
  logic [63:0] frame [SCREEN_ROWS];

  state_t state, state_next;
  req_t   cur;
  rsp_t   out;
  logic   out_valid;
  logic   in_ready;
  logic [15:0] word;
  logic [7:0]  mem_q;
  logic [63:0] row_q;
  logic [4:0]  cnt;
  logic [3:0]  row_cnt;
  logic        hit;
  logic [7:0]  bcd_rem, bcd_h, bcd_t;
  logic [1:0]  bcd_ph;
  logic        clr_busy;

  // memory and frame port controls
  logic        m_we;
  logic [11:0] m_addr;
  logic [7:0]  m_wd;
  logic        f_we;
  logic [4:0]  f_addr;
  logic [63:0] f_wd;

  always_ff @(posedge clk) begin
    if (m_we) begin
      mem[m_addr] <= m_wd;
    end
    mem_q <= mem[m_addr];
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      frame[f_addr] <= f_wd;
    end
    row_q <= frame[f_addr];
  end

  // instruction fields
  logic [3:0] x, y, nib;
  logic [7:0] nn, vx, vy;
  assign x = word[11:8];
  assign y = word[7:4];
  assign nib = word[3:0];
  assign nn = word[7:0];
  assign vx = vreg[x];
  assign vy = vreg[y];

  // shared 8-bit subtractor: ALU subtracts, BCD digit extraction
  logic [7:0] sub_a, sub_b;
  logic [8:0] sub_r;
  assign sub_r = {1'b0, sub_a} - {1'b0, sub_b};

  // sprite shifted into its columns, with wrap
  logic [7:0]   spr;
  logic [127:0] spr_wide;
  logic [63:0]  spr_mask;
  logic [5:0]   col0;
  logic [4:0]   row_addr;
  assign spr = mem_q;
  assign col0 = vx[5:0];
  assign spr_wide = {spr, 120'd0} >> col0;
  assign spr_mask = spr_wide[127:64] | spr_wide[63:0];
  assign row_addr = vy[4:0] + {1'b0, row_cnt};

  // accept only when idle, cleared and with no response waiting
  assign in_ready = (state == S_IDLE) && !clr_busy && !out_valid;
  assign req.ready = in_ready;
  assign rsp.valid = out_valid;
  assign rsp.data = out;

  always_comb begin
    sub_a = vx;
    sub_b = vy;
    if (state == S_BCD_DIV) begin
      sub_a = bcd_rem;
      sub_b = (bcd_ph == 2'd0) ? 8'd100 : 8'd10;
    end else if (state == S_DECODE && nib == 4'h7) begin
      sub_a = vy;
      sub_b = vx;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    m_we = 1'b0;
    m_addr = cur.address;
    m_wd = cur.write_value;
    f_we = 1'b0;
    f_addr = cur.address[4:0];
    f_wd = 64'd0;
    pc_next = pc;
    index_next = index_reg;
    sp_next = sp;
    case (state)
      S_IDLE: begin
        m_addr = req.data.address;
        f_addr = req.data.address[4:0];
        if (clr_busy) begin
          f_we = 1'b1;
          f_addr = cnt;
        end else if (req.valid && in_ready) begin
          case (op_t'(req.data.op))
            OP_WRITE: state_next = S_MEMWR;
            OP_STEP:  state_next = S_FETCH_HI;
            OP_ROW:   state_next = S_ROWRD;
            default:  state_next = S_MEMRD;
          endcase
        end
      end
      S_MEMWR: begin
        m_we = 1'b1;
        state_next = S_DONE;
      end
      S_ROWRD: state_next = S_DONE;
      S_MEMRD: state_next = S_MEMRD_W;
      S_MEMRD_W: state_next = S_DONE;
      S_FETCH_HI: begin
        m_addr = pc;
        state_next = S_FETCH_LO;
      end
      S_FETCH_LO: begin
        m_addr = pc + 12'd1;
        state_next = S_FETCH_W;
      end
      S_FETCH_W: begin
        m_addr = pc + 12'd1;
        state_next = S_DECODE;
      end
      S_DECODE: begin
        pc_next = pc + 12'd2;
        state_next = S_DONE;
        case (word[15:12])
          4'h0: begin
            if (word[11:0] == 12'h0E0) begin
              state_next = S_CLS;
            end else if (word[11:0] == 12'h0EE) begin
              sp_next = sp - 1'b1;
              pc_next = stack[sp - 1'b1] + 12'd2;
            end
          end
          4'h1: pc_next = word[11:0];
          4'h2: begin
            sp_next = sp + 1'b1;
            pc_next = word[11:0];
          end
          4'h3: if (vx == nn) pc_next = pc + 12'd4;
          4'h4: if (vx != nn) pc_next = pc + 12'd4;
          4'h5: if (vx == vy) pc_next = pc + 12'd4;
          4'h9: if (vx != vy) pc_next = pc + 12'd4;
          4'hA: index_next = word[11:0];
          4'hB: pc_next = word[11:0] + {4'd0, vreg[0]};
          4'hD: begin
            m_addr = index_reg;
            state_next = (nib == 4'd0) ? S_DRAW_DONE : S_DRAW_RD;
          end
          4'hE: begin
            if (nn == 8'h9E && cur.key_state[vx[3:0]]) pc_next = pc + 12'd4;
            if (nn == 8'hA1 && !cur.key_state[vx[3:0]]) pc_next = pc + 12'd4;
          end
          4'hF: begin
            if (nn == 8'h1E) index_next = index_reg + {4'd0, vx};
            if (nn == 8'h33) state_next = S_BCD_DIV;
          end
          default: ;
        endcase
      end
      S_CLS: begin
        f_we = 1'b1;
        f_addr = cnt;
        if (cnt == 5'(SCREEN_ROWS - 1)) state_next = S_DONE;
      end
      S_DRAW_RD: begin
        m_addr = index_reg + {8'd0, row_cnt};
        state_next = S_DRAW_W;
      end
      S_DRAW_W: begin
        m_addr = index_reg + {8'd0, row_cnt};
        f_addr = row_addr;
        state_next = S_DRAW_ROW;
      end
      S_DRAW_ROW: begin
        m_addr = index_reg + {8'd0, row_cnt};
        f_addr = row_addr;
        state_next = S_DRAW_WR;
      end
      S_DRAW_WR: begin
        f_we = 1'b1;
        f_addr = row_addr;
        f_wd = row_q ^ spr_mask;
        state_next = (row_cnt == nib - 4'd1) ? S_DRAW_DONE : S_DRAW_RD;
      end
      S_DRAW_DONE: state_next = S_DONE;
      S_BCD_DIV: begin
        if (bcd_ph == 2'd2) state_next = S_BCD_WR;
      end
      S_BCD_WR: begin
        m_we = 1'b1;
        m_addr = index_reg + {10'd0, cnt[1:0]};
        m_wd = (cnt[1:0] == 2'd0) ? bcd_h : (cnt[1:0] == 2'd1) ? bcd_t : bcd_rem;
        if (cnt[1:0] == 2'd2) state_next = S_DONE;
      end
      S_DONE: if (!out_valid) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= START_PC;
      index_reg <= 12'd0;
      sp <= '0;
      delay_count <= 8'd0;
      sound_count <= 8'd0;
      out_valid <= 1'b0;
      clr_busy <= 1'b1;
      cnt <= 5'd0;
      for (int i = 0; i < 16; i++) vreg[i] <= 8'd0;
      for (int i = 0; i < STACK_DEPTH; i++) stack[i] <= 12'd0;
    end else begin
      state <= state_next;
      pc <= pc_next;
      index_reg <= index_next;
      sp <= sp_next;
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      // post-reset frame clear sweep
      if (clr_busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(SCREEN_ROWS - 1)) clr_busy <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid && in_ready) begin
            cur <= req.data;
            word <= 16'd0;
            hit <= 1'b0;
            row_cnt <= 4'd0;
            cnt <= 5'd0;
            out.drew_sprite <= 1'b0;
            out.unknown_instr <= 1'b0;
            out.read_data <= 64'd0;
          end
        end
        S_ROWRD: out.read_data <= row_q;
        S_MEMRD_W: out.read_data <= {56'd0, mem_q};
        // mem_q is registered: high byte is captured in S_FETCH_LO, low byte in S_FETCH_W
        S_FETCH_LO: word[15:8] <= mem_q;
        S_FETCH_W: word[7:0] <= mem_q;
        S_CLS: cnt <= cnt + 5'd1;
        S_DRAW_WR: begin
          row_cnt <= row_cnt + 4'd1;
          if ((row_q & spr_mask) != 64'd0) hit <= 1'b1;
        end
        S_DRAW_DONE: begin
          vreg[15] <= {7'd0, hit};
          out.drew_sprite <= 1'b1;
        end
        S_BCD_DIV: begin
          if (bcd_ph == 2'd2) begin
            cnt <= 5'd0;
          end else if (sub_r[8]) begin
            bcd_ph <= bcd_ph + 2'd1;
          end else begin
            bcd_rem <= sub_r[7:0];
            if (bcd_ph == 2'd0) bcd_h <= bcd_h + 8'd1;
            else bcd_t <= bcd_t + 8'd1;
          end
        end
        S_BCD_WR: cnt <= cnt + 5'd1;
        default: ;
      endcase
      if (state == S_DECODE) begin
        bcd_rem <= vx;
        bcd_h <= 8'd0;
        bcd_t <= 8'd0;
        bcd_ph <= 2'd0;
        case (word[15:12])
          4'h0: if (word[11:0] != 12'h0E0 && word[11:0] != 12'h0EE)
            out.unknown_instr <= 1'b1;
          4'h2: stack[sp] <= pc;
          4'h6: vreg[x] <= nn;
          4'h7: vreg[x] <= vx + nn;
          4'h8: begin
            case (nib)
              4'h0: vreg[x] <= vy;
              4'h1: vreg[x] <= vx | vy;
              4'h2: vreg[x] <= vx & vy;
              4'h3: vreg[x] <= vx ^ vy;
              4'h4: begin
                vreg[x] <= vx + vy;
                vreg[15] <= {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'd255};
              end
              4'h5, 4'h7: begin
                vreg[x] <= sub_r[7:0];
                vreg[15] <= {7'd0, !sub_r[8]};
              end
              4'h6: begin
                vreg[x] <= {1'b0, vy[7:1]};
                vreg[15] <= {7'd0, vy[0]};
              end
              4'hE: begin
                vreg[x] <= {vy[6:0], 1'b0};
                vreg[15] <= {7'd0, vy[7]};
              end
              default: out.unknown_instr <= 1'b1;
            endcase
          end
          4'hC: vreg[x] <= cur.random_byte & nn;
          4'hE: if (nn != 8'h9E && nn != 8'hA1) out.unknown_instr <= 1'b1;
          4'hF: begin
            case (nn)
              8'h07: vreg[x] <= delay_count;
              8'h15: delay_count <= vx;
              8'h18: sound_count <= vx;
              8'h1E, 8'h33: ;
              default: out.unknown_instr <= 1'b1;
            endcase
          end
          default: ;
        endcase
      end
      if (state == S_DONE && !out_valid) begin
        out_valid <= 1'b1;
        out.pc_after <= pc;
        out.fetched_word <= word;
      end
    end
  end
endmodule
`default_nettype wire

// File: hdl/c8x_checker.sv
// Checker: port-level properties of the CHIP-8 executor, bound to the top.
`include "chip8_instruction_executor_unit_defines.svh"
`default_nettype none
module c8x_checker
  import c8x_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp_data
);
  // one request in flight: no acceptance while a response is pending
  `C8_ASSERT_IMPL(a_no_overlap, clk, rst, rsp_valid, !req_ready, "ready while response pending")
  // accepted request is never answered in the same or next cycle
  `C8_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !rsp_valid && !req_ready, "response too early")
  // stalled response holds its payload
  `C8_ASSERT_NEXT(a_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed under stall")
  // a read (no fetched word, nonzero read data) never carries the draw flag
  `C8_ASSERT_IMPL(a_flags, clk, rst, rsp_valid && rsp_data.fetched_word == 16'd0 && rsp_data.read_data != 64'd0, !rsp_data.drew_sprite, "draw flag on a read")
endmodule

bind chip8_instruction_executor_unit c8x_checker u_c8x_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_data(rsp.data)
);
`default_nettype wire

// File: test/testbench.sv
// Testbench for the CHIP-8 instruction executor: random programs checked against a local emulator.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import c8x_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int ITEM_TARGET = 1300;
  localparam int HOLDOFF_AT = 200;
  localparam int HOLDOFF_LEN = 400;
  localparam int PAUSE_AT = 800;
  localparam int QUIET_LO = 400;
  localparam int QUIET_HI = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;

  c8x_chan_if #(.payload_t(req_t)) req_ch ();
  c8x_chan_if #(.payload_t(rsp_t)) rsp_ch ();

  chip8_instruction_executor_unit DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Emulator state of the executor
  logic [7:0]  emu_mem [4096];
  bit          emu_written [4096];
  logic [11:0] written_list [$];
  logic [7:0]  emu_v [16];
  logic [11:0] emu_pc;
  logic [11:0] emu_i;
  logic [11:0] emu_stack [STACK_DEPTH];
  logic [SP_W-1:0] emu_sp;
  logic [7:0]  emu_delay;
  logic [7:0]  emu_sound;
  logic [63:0] emu_frame [SCREEN_ROWS];

  // Requests waiting to be driven, each paired with its predicted response
  req_t pend_req [$];
  rsp_t pend_rsp [$];
  // Responses owed by the block for accepted requests
  rsp_t owed_rsp [$];

  int accepted_reqs = 0;
  int seen_rsps = 0;
  int errors = 0;
  int item_count = 0;

  function automatic void emu_store(logic [11:0] a, logic [7:0] val);
    emu_mem[a] = val;
    if (!emu_written[a]) begin
      emu_written[a] = 1'b1;
      written_list.push_back(a);
    end
  endfunction

  // Run one request through the emulator and return the expected response
  function automatic rsp_t emulate_item(req_t r);
    rsp_t o;
    logic [15:0] w;
    logic [3:0] x, y, n;
    logic [7:0] nn, vx, vy, bits;
    logic [8:0] sum;
    logic [11:0] nnn, nxt;
    logic [4:0] row;
    logic [5:0] col;
    logic [63:0] m;
    logic hit, pressed;
    o = '0;
    case (op_t'(r.op))
      OP_WRITE: emu_store(r.address, r.write_value);
      OP_ROW: o.read_data = emu_frame[r.address[4:0]];
      OP_READ: o.read_data = {56'd0, emu_mem[r.address]};
      default: begin
        w = {emu_mem[emu_pc], emu_mem[emu_pc + 12'd1]};
        o.fetched_word = w;
        x = w[11:8];
        y = w[7:4];
        n = w[3:0];
        nn = w[7:0];
        nnn = w[11:0];
        vx = emu_v[x];
        vy = emu_v[y];
        nxt = emu_pc + 12'd2;
        case (w[15:12])
          4'h0: begin
            if (nnn == 12'h0E0) begin
              for (int k = 0; k < SCREEN_ROWS; k++) emu_frame[k] = '0;
            end else if (nnn == 12'h0EE) begin
              emu_sp = emu_sp - 1'b1;
              nxt = emu_stack[emu_sp] + 12'd2;
            end else begin
              o.unknown_instr = 1'b1;
            end
          end
          4'h1: nxt = nnn;
          4'h2: begin
            emu_stack[emu_sp] = emu_pc;
            emu_sp = emu_sp + 1'b1;
            nxt = nnn;
          end
          4'h3: if (vx == nn) nxt = emu_pc + 12'd4;
          4'h4: if (vx != nn) nxt = emu_pc + 12'd4;
          4'h5: if (vx == vy) nxt = emu_pc + 12'd4;
          4'h6: emu_v[x] = nn;
          4'h7: emu_v[x] = vx + nn;
          4'h8: begin
            case (n)
              4'h0: emu_v[x] = vy;
              4'h1: emu_v[x] = vx | vy;
              4'h2: emu_v[x] = vx & vy;
              4'h3: emu_v[x] = vx ^ vy;
              4'h4: begin
                sum = vx + vy;
                emu_v[x] = sum[7:0];
                emu_v[15] = {7'd0, sum[8]};
              end
              4'h5: begin
                emu_v[x] = vx - vy;
                emu_v[15] = {7'd0, vx >= vy};
              end
              4'h6: begin
                emu_v[x] = vy >> 1;
                emu_v[15] = {7'd0, vy[0]};
              end
              4'h7: begin
                emu_v[x] = vy - vx;
                emu_v[15] = {7'd0, vy >= vx};
              end
              4'hE: begin
                emu_v[x] = vy << 1;
                emu_v[15] = {7'd0, vy[7]};
              end
              default: o.unknown_instr = 1'b1;
            endcase
          end
          4'h9: if (vx != vy) nxt = emu_pc + 12'd4;
          4'hA: emu_i = nnn;
          4'hB: nxt = nnn + {4'd0, emu_v[0]};
          4'hC: emu_v[x] = r.random_byte & nn;
          4'hD: begin
            hit = 1'b0;
            for (int rr = 0; rr < n; rr++) begin
              bits = emu_mem[emu_i + rr[11:0]];
              row = vy[4:0] + rr[4:0];
              for (int c = 0; c < 8; c++) begin
                if (bits[7-c]) begin
                  col = vx[5:0] + c[5:0];
                  m = 64'd1 << (63 - col);
                  if ((emu_frame[row] & m) != 0) hit = 1'b1;
                  emu_frame[row] ^= m;
                end
              end
            end
            emu_v[15] = {7'd0, hit};
            o.drew_sprite = 1'b1;
          end
          4'hE: begin
            pressed = r.key_state[vx[3:0]];
            if (nn == 8'h9E) begin
              if (pressed) nxt = emu_pc + 12'd4;
            end else if (nn == 8'hA1) begin
              if (!pressed) nxt = emu_pc + 12'd4;
            end else begin
              o.unknown_instr = 1'b1;
            end
          end
          default: begin
            case (nn)
              8'h07: emu_v[x] = emu_delay;
              8'h15: emu_delay = vx;
              8'h18: emu_sound = vx;
              8'h1E: emu_i = emu_i + {4'd0, vx};
              8'h33: begin
                emu_store(emu_i, vx / 100);
                emu_store(emu_i + 12'd1, (vx / 10) % 10);
                emu_store(emu_i + 12'd2, vx % 10);
              end
              default: o.unknown_instr = 1'b1;
            endcase
          end
        endcase
        emu_pc = nxt;
      end
    endcase
    o.pc_after = emu_pc;
    return o;
  endfunction

  function automatic void queue_item(logic [1:0] op, logic [11:0] a, logic [7:0] val);
    req_t r;
    r.op = op;
    r.address = a;
    r.write_value = val;
    r.key_state = 16'($urandom);
    r.random_byte = 8'($urandom);
    pend_req.push_back(r);
    pend_rsp.push_back(emulate_item(r));
    item_count++;
  endfunction

  // Step once; load the word at PC first if asked or unwritten, and fill any unwritten sprite bytes
  function automatic void queue_step(bit load, logic [15:0] word);
    logic [15:0] w;
    if (load || !emu_written[emu_pc]) queue_item(OP_WRITE, emu_pc, word[15:8]);
    if (load || !emu_written[emu_pc + 12'd1]) queue_item(OP_WRITE, emu_pc + 12'd1, word[7:0]);
    w = {emu_mem[emu_pc], emu_mem[emu_pc + 12'd1]};
    if (w[15:12] == 4'hD) begin
      for (int rr = 0; rr < w[3:0]; rr++) begin
        if (!emu_written[emu_i + rr[11:0]])
          queue_item(OP_WRITE, emu_i + rr[11:0], 8'($urandom));
      end
    end
    queue_item(OP_STEP, 12'($urandom), 8'($urandom));
  endfunction

  function automatic logic [15:0] random_instr();
    logic [15:0] w;
    int pick;
    w = 16'($urandom);
    pick = $urandom_range(9);
    case (w[15:12])
      4'h0: begin
        if (pick < 2) w[11:0] = 12'h0E0;
        else if (pick < 7) w[11:0] = 12'h0EE;
      end
      4'h8: if (pick < 8) w[3:0] = (pick == 7) ? 4'hE : 4'($urandom_range(7));
      4'hD: if (pick < 6) w[3:0] = 4'($urandom_range(4));
      4'hE: if (pick < 8) w[7:0] = (pick < 4) ? 8'h9E : 8'hA1;
      4'hF: begin
        case (pick)
          0: w[7:0] = 8'h07;
          1: w[7:0] = 8'h15;
          2: w[7:0] = 8'h18;
          3: w[7:0] = 8'h1E;
          4, 5: w[7:0] = 8'h33;
          6: w[7:0] = 8'h0A;
          7: w[7:0] = 8'h29;
          8: w[7:0] = (w[0]) ? 8'h55 : 8'h65;
          default: ;
        endcase
      end
      default: ;
    endcase
    return w;
  endfunction

  // Drive requests from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        void'(pend_req.pop_front());
        owed_rsp.push_back(pend_rsp.pop_front());
        accepted_reqs++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pend_req.size() == 0 ||
            (accepted_reqs == PAUSE_AT && owed_rsp.size() != 0) ||
            (!(accepted_reqs >= QUIET_LO && accepted_reqs < QUIET_HI) &&
             $urandom_range(99) < 19)) begin
          req_ch.valid <= 1'b0;
        end else begin
          req_ch.valid <= 1'b1;
          req_ch.data <= pend_req[0];
        end
      end
    end
  end

  // Accept responses and check them against the owed ones
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;
  always @(posedge clk) begin
    rsp_t e;
    rsp_t a;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        a = rsp_ch.data;
        seen_rsps++;
        if (owed_rsp.size() == 0) begin
          $display("%0t: response with none owed: %p", $time, a);
          errors++;
        end else begin
          e = owed_rsp.pop_front();
          if (a.pc_after !== e.pc_after) begin
            $display("%0t: pc_after expected %h actual %h", $time, e.pc_after, a.pc_after);
            errors++;
          end
          if (a.fetched_word !== e.fetched_word) begin
            $display("%0t: fetched_word expected %h actual %h", $time,
                     e.fetched_word, a.fetched_word);
            errors++;
          end
          if (a.drew_sprite !== e.drew_sprite) begin
            $display("%0t: drew_sprite expected %b actual %b", $time,
                     e.drew_sprite, a.drew_sprite);
            errors++;
          end
          if (a.unknown_instr !== e.unknown_instr) begin
            $display("%0t: unknown_instr expected %b actual %b", $time,
                     e.unknown_instr, a.unknown_instr);
            errors++;
          end
          if (a.read_data !== e.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, e.read_data, a.read_data);
            errors++;
          end
        end
      end
      // Hold off once for a long stretch so the block backs up
      if (!holdoff_done && seen_rsps >= HOLDOFF_AT) begin
        holdoff_done <= 1'b1;
        holdoff_left <= HOLDOFF_LEN;
        rsp_ch.ready <= 1'b0;
      end else if (holdoff_left > 0) begin
        holdoff_left <= holdoff_left - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ((seen_rsps >= QUIET_LO && seen_rsps < QUIET_HI) ||
                         $urandom_range(99) >= 19);
      end
    end
  end

  // End the run when nothing is accepted for too long
  int stuck_cycles = 0;
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    logic [15:0] directed [$];
    int pick;
    logic [11:0] a;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;

    // Reset image of the emulator
    emu_pc = START_PC;
    emu_i = '0;
    emu_sp = '0;
    emu_delay = '0;
    emu_sound = '0;
    for (int k = 0; k < 16; k++) emu_v[k] = '0;
    for (int k = 0; k < STACK_DEPTH; k++) emu_stack[k] = '0;
    for (int k = 0; k < SCREEN_ROWS; k++) emu_frame[k] = '0;
    for (int k = 0; k < 4096; k++) begin
      emu_mem[k] = '0;
      emu_written[k] = 1'b0;
    end

    // Directed: carry, borrow, shifts, wrapped draw with collision, clear, call/return, BCD,
    // timers, keys, random mask, jump plus V0 and unsupported words
    directed = '{16'h60FF, 16'h6101, 16'h8014, 16'h8115, 16'h8F17, 16'h80F6, 16'h80FE,
                 16'h8018, 16'hAFFE, 16'h6A3C, 16'h6B1E, 16'hDABF, 16'hDABF, 16'h00E0,
                 16'h6CFF, 16'hFC33, 16'hFC15, 16'hF007, 16'hFC18, 16'hEC9E, 16'hECA1,
                 16'hC3FF, 16'h0123, 16'hF029, 16'h2400, 16'h00EE, 16'hB2F0};
    foreach (directed[k]) queue_step(1'b1, directed[k]);
    queue_item(OP_ROW, 12'hFFF, 8'h00);
    queue_item(OP_READ, 12'hFFE, 8'h00);

    // Random: mostly execution, with writes and reads of rows and memory mixed in
    while (item_count < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        queue_step(1'b1, random_instr());
      end else if (pick < 60) begin
        queue_step(1'b0, random_instr());
      end else if (pick < 75) begin
        queue_item(OP_ROW, 12'($urandom), 8'($urandom));
      end else if (pick < 87) begin
        a = 12'($urandom);
        if (!emu_written[a]) a = written_list[$urandom_range(written_list.size() - 1)];
        queue_item(OP_READ, a, 8'($urandom));
      end else begin
        queue_item(OP_WRITE, 12'($urandom), 8'($urandom));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pend_req.size() != 0 || owed_rsp.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
